FILE: rtl/core/bqd_pkg.sv
// Shared types and constants for the block dequantizer.
`default_nettype none
package bqd_pkg;

  // Formats selected by the format register.
  localparam logic [1:0] FMT_F16  = 2'd0;
  localparam logic [1:0] FMT_BF16 = 2'd1;
  localparam logic [1:0] FMT_Q4   = 2'd2;
  localparam logic [1:0] FMT_Q8   = 2'd3;

  // Kinds of work handed from the front to the back.
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_Q4    = 2'd1;
  localparam logic [1:0] KIND_Q8    = 2'd2;

  // Block lengths in words, scale word included.
  localparam logic [4:0] Q4_BLOCK_WORDS = 5'd9;
  localparam logic [4:0] Q8_BLOCK_WORDS = 5'd17;

  // Default queue depths.
  localparam int JOB_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // One classified word waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [31:0] scale;   // block scale, or the finished value for plain words
    logic [4:0]  pos;     // position of the first element of this word
    logic        done;    // word closes a block (always set for plain words)
  } job_t;

  // One finished result element.
  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  position;
    logic        block_done;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/bqd_fifo.sv
// Small register-based first-in first-out queue.
`default_nettype none
module bqd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           din,
  output logic                            full,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                dout,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bqd_front.sv
// Front end: takes input words, tracks block position and scale, classifies work.
`default_nettype none
module bqd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_data,
  input  wire logic            push,
  input  wire logic [15:0]     word,
  input  wire logic            restart,
  output logic                 full,
  input  wire logic            job_full,
  output logic                 job_push,
  output bqd_pkg::job_t        job
);

  logic [1:0]  format;
  logic [4:0]  word_in_block;
  logic [4:0]  word_in_block_next;
  logic [31:0] block_scale;
  logic [31:0] block_scale_next;
  logic        accept;
  logic [4:0]  blen;
  logic [4:0]  idx;
  logic [31:0] half_val;

  // Exact f16 to f32 conversion; infinity and NaN become +0.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lead;
    logic [22:0] frac;
    logic [31:0] res;
    ex   = h[14:10];
    man  = h[9:0];
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        lead = 4'(i);
      end
    end
    frac = 23'({13'd0, man} << (5'd23 - {1'b0, lead}));
    if (ex == 5'd0) begin
      if (man == '0) begin
        res = {h[15], 31'd0};
      end else begin
        res = {h[15], 8'd103 + {4'd0, lead}, frac};
      end
    end else if (ex == 5'h1f) begin
      res = '0;
    end else begin
      res = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return res;
  endfunction

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign half_val = half_to_f32(word);

  // Classify the word against the current block position.
  always_comb begin
    blen = (format == bqd_pkg::FMT_Q4) ? bqd_pkg::Q4_BLOCK_WORDS : bqd_pkg::Q8_BLOCK_WORDS;
    idx  = restart ? 5'd0 : word_in_block;
    if (idx >= blen) begin
      idx = 5'd0;
    end
    word_in_block_next = word_in_block;
    block_scale_next   = block_scale;
    job_push           = 1'b0;
    job.kind           = bqd_pkg::KIND_PLAIN;
    job.word           = word;
    job.scale          = block_scale;
    job.pos            = {idx[3:0] - 4'd1, 1'b0};
    job.done           = (idx == blen - 5'd1);
    case (format)
      bqd_pkg::FMT_F16, bqd_pkg::FMT_BF16: begin
        word_in_block_next = '0;
        job_push           = accept;
        job.scale          = (format == bqd_pkg::FMT_F16) ? half_val : {word, 16'd0};
        job.pos            = '0;
        job.done           = 1'b1;
      end
      default: begin
        if (idx == 5'd0) begin
          word_in_block_next = 5'd1;
          block_scale_next   = half_val;
        end else begin
          word_in_block_next = job.done ? 5'd0 : idx + 5'd1;
          job_push           = accept;
          job.kind = (format == bqd_pkg::FMT_Q4) ? bqd_pkg::KIND_Q4 : bqd_pkg::KIND_Q8;
        end
      end
    endcase
  end

  // Format register and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      format        <= bqd_pkg::FMT_F16;
      word_in_block <= '0;
      block_scale   <= '0;
    end else begin
      if (cfg_we) begin
        format <= cfg_data;
      end
      if (accept) begin
        word_in_block <= word_in_block_next;
        block_scale   <= block_scale_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bqd_back.sv
// Back end: expands each job into elements, multiplies and normalizes quantized ones; plain words pass through.
`default_nettype none
module bqd_back #(
  parameter int OUT_DEPTH = bqd_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_empty,
  input  wire bqd_pkg::job_t                 job,
  output logic                               job_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                               res_push,
  output bqd_pkg::result_t                   res
);

  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam logic [CW:0] DEPTH_C = (CW+1)'(OUT_DEPTH);

  logic [1:0]  elem;
  logic [1:0]  last_elem;
  logic [CW:0] occ;
  logic        issue;
  logic        is_last;
  logic [3:0]  nib;
  logic [7:0]  qbyte;
  logic [7:0]  aq;
  logic        qneg;
  logic [4:0]  pos;

  // Stage one registers.
  logic        s1_valid;
  logic        s1_plain;
  logic [31:0] s1_plain_val;
  logic        s1_sign;
  logic [7:0]  s1_exp;
  logic        s1_zero;
  logic [31:0] s1_prod;
  logic [4:0]  s1_pos;
  logic        s1_done;
  logic        s1_last;

  logic [3:0]  sh;
  logic [31:0] shifted;

  // Issue one element per cycle while a job is waiting and the result queue has room.
  assign occ       = {1'b0, out_count} + {{CW{1'b0}}, s1_valid};
  assign issue     = !job_empty && (occ < DEPTH_C);
  assign last_elem = (job.kind == bqd_pkg::KIND_Q4) ? 2'd3 :
                     (job.kind == bqd_pkg::KIND_Q8) ? 2'd1 : 2'd0;
  assign is_last   = (elem == last_elem);
  assign job_pop   = issue && is_last;

  // Select the quant and its position for the current element.
  always_comb begin
    nib   = '0;
    qbyte = '0;
    aq    = '0;
    qneg  = 1'b0;
    pos   = job.pos;
    case (job.kind)
      bqd_pkg::KIND_Q4: begin
        case (elem)
          2'd0: begin nib = job.word[3:0];   pos = job.pos;          end
          2'd1: begin nib = job.word[7:4];   pos = job.pos + 5'd16;  end
          2'd2: begin nib = job.word[11:8];  pos = job.pos + 5'd1;   end
          default: begin nib = job.word[15:12]; pos = job.pos + 5'd17; end
        endcase
        qneg = !nib[3];
        aq   = nib[3] ? {5'd0, nib[2:0]} : 8'd8 - {4'd0, nib};
      end
      bqd_pkg::KIND_Q8: begin
        qbyte = elem[0] ? job.word[15:8] : job.word[7:0];
        pos   = job.pos + {4'd0, elem[0]};
        qneg  = qbyte[7];
        aq    = qneg ? 8'd0 - qbyte : qbyte;
      end
      default: begin
        pos = '0;
      end
    endcase
  end

  // Element counter and stage one: the mantissa product.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        elem <= is_last ? 2'd0 : elem + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_plain     <= (job.kind == bqd_pkg::KIND_PLAIN);
      s1_plain_val <= job.scale;
      s1_sign      <= job.scale[31] ^ qneg;
      s1_exp       <= job.scale[30:23];
      s1_zero      <= (job.scale[30:0] == '0) || (aq == '0);
      s1_prod      <= {1'b1, job.scale[22:0]} * aq;
      s1_pos       <= pos;
      s1_done      <= is_last && job.done;
      s1_last      <= is_last;
    end
  end

  // Stage two: find the leading one and pack the float.
  always_comb begin
    sh = '0;
    for (int i = 0; i < 9; i++) begin
      if (s1_prod[23 + i]) begin
        sh = 4'(i);
      end
    end
    shifted = s1_prod >> sh;
  end

  assign res_push = s1_valid;

  always_comb begin
    res.position   = s1_pos;
    res.block_done = s1_done;
    res.last       = s1_last;
    if (s1_plain) begin
      res.value = s1_plain_val;
    end else if (s1_zero) begin
      res.value = {s1_sign, 31'd0};
    end else begin
      res.value = {s1_sign, s1_exp + {4'd0, sh}, shifted[22:0]};
    end
  end

  a_issue_has_job: assert property (@(posedge clk) disable iff (rst)
    issue |-> !job_empty) else $error("element issued with no job");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (out_count < DEPTH_C[CW-1:0]) || (DEPTH_C[CW] == 1'b1))
    else $error("result queue would overflow");
  a_mid_job_held: assert property (@(posedge clk) disable iff (rst)
    (elem != 2'd0) |-> !job_empty) else $error("job left mid expansion");
  a_q8_count: assert property (@(posedge clk) disable iff (rst)
    (!job_empty && job.kind == bqd_pkg::KIND_Q8) |-> (elem < 2'd2))
    else $error("q8_0 element counter out of range");
  a_stage_follows: assert property (@(posedge clk) disable iff (rst)
    issue |=> s1_valid) else $error("issued element lost");

endmodule
`default_nettype wire

FILE: rtl/core/block_quant_dequantizer.sv
// Top level of the block dequantizer: front, job queue, back and result queue.
//
//  channel   direction  handshake          payload
//  input     in         push / full        word[15:0], restart
//  result    out        pop / empty        value[31:0], position[4:0], block_done, last
//  config    in         cfg_we             cfg_data[1:0] (format)
//
// The front takes one word per cycle while the job queue has room; scale words
// make no result. The back issues one element per cycle while the result queue
// has room: one for an f16/bf16 word, two for q8_0 and four for q4_0. Results
// pass the job queue, the stage one register and the result queue on their way
// to the result ports; the other results of a word follow at the same rate.
// Reset is synchronous and clears format, block position, scale and queues.
// A stalled result queue fills and then backs up through the job queue to full.
`default_nettype none
module block_quant_dequantizer #(
  parameter int JOB_DEPTH = bqd_pkg::JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = bqd_pkg::OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] word,
  input  wire logic        restart,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      value,
  output logic [4:0]       position,
  output logic             block_done,
  output logic             last
);

  localparam int JW = $bits(bqd_pkg::job_t);
  localparam int RW = $bits(bqd_pkg::result_t);

  bqd_pkg::job_t    job_in;
  bqd_pkg::job_t    job_head;
  bqd_pkg::result_t res_in;
  bqd_pkg::result_t res_head;
  logic             job_push;
  logic             job_full;
  logic             job_empty;
  logic             job_pop;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
  logic             res_push;
  logic             res_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // Front end.
  bqd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .word     (word),
    .restart  (restart),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  // Queue between front and back.
  bqd_fifo #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (job_empty),
    .count (job_count)
  );

  // Back end.
  bqd_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue.
  bqd_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty),
    .count (out_count)
  );

  assign value      = res_head.value;
  assign position   = res_head.position;
  assign block_done = res_head.block_done;
  assign last       = res_head.last;

  a_job_count: assert property (@(posedge clk) disable iff (rst)
    job_full |-> (job_count != '0)) else $error("job queue count inconsistent");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_push_blocked: assert property (@(posedge clk) disable iff (rst)
    job_full |-> !job_push) else $error("job pushed into full queue");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the block dequantizer: random and directed words, scoreboard check.
module tb_top;

  // Predicts dequantized elements and holds them until the block delivers them.
  class dequant_scoreboard;
    bqd_pkg::result_t pending[$];
    logic [1:0] fmt;
    logic [4:0] word_idx;
    logic [31:0] scale;
    int errors;

    function new();
      fmt = bqd_pkg::FMT_F16;
      word_idx = 0;
      scale = 0;
      errors = 0;
    endfunction

    // Magnitude of a normal or zero float32 pattern.
    function real f32_mag(logic [31:0] b);
      if (b[30:23] == 0) return 0.0;
      return $bitstoreal({1'b0, 11'(int'(b[30:23]) + 896), b[22:0], 29'b0});
    endfunction

    // Exact magnitude to float32 bits; every product here is exact and normal.
    function logic [31:0] to_f32(bit s, real mag);
      logic [63:0] d;
      d = $realtobits(mag);
      if (mag == 0.0) return {s, 31'b0};
      return {s, 8'(int'(d[62:52]) - 896), d[51:29]};
    endfunction

    // Half to single; infinity and NaN become +0.
    function logic [31:0] half_to_single(logic [15:0] h);
      if (h[14:10] == 0) return to_f32(h[15], real'(h[9:0]) / 16777216.0);
      if (h[14:10] == 5'h1f) return 32'b0;
      return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'b0};
    endfunction

    function logic [31:0] scaled(int q);
      return to_f32(scale[31] ^ (q < 0), f32_mag(scale) * ((q < 0) ? -q : q));
    endfunction

    function void add(logic [31:0] v, logic [4:0] p, logic d, logic l);
      bqd_pkg::result_t r;
      r.value = v;
      r.position = p;
      r.block_done = d;
      r.last = l;
      pending.push_back(r);
    endfunction

    // Works out the results of one accepted word.
    function void note(logic [15:0] w, logic rs);
      logic [4:0] blen, idx, p;
      logic done;
      if (rs) word_idx = 0;
      if (fmt == bqd_pkg::FMT_F16 || fmt == bqd_pkg::FMT_BF16) begin
        word_idx = 0;
        add((fmt == bqd_pkg::FMT_F16) ? half_to_single(w) : {w, 16'b0}, 0, 1, 1);
        return;
      end
      blen = (fmt == bqd_pkg::FMT_Q4) ? bqd_pkg::Q4_BLOCK_WORDS : bqd_pkg::Q8_BLOCK_WORDS;
      idx = (word_idx >= blen) ? 5'd0 : word_idx;
      if (idx == 0) begin
        scale = half_to_single(w);
        word_idx = 1;
        return;
      end
      done = (idx == blen - 1);
      word_idx = done ? 5'd0 : idx + 5'd1;
      p = 5'(2 * (idx - 1));
      if (fmt == bqd_pkg::FMT_Q4) begin
        add(scaled(int'(w[3:0]) - 8), p, 0, 0);
        add(scaled(int'(w[7:4]) - 8), p + 5'd16, 0, 0);
        add(scaled(int'(w[11:8]) - 8), p + 5'd1, 0, 0);
        add(scaled(int'(w[15:12]) - 8), p + 5'd17, done, 1);
      end else begin
        add(scaled(int'($signed(w[7:0]))), p, 0, 0);
        add(scaled(int'($signed(w[15:8]))), p + 5'd1, done, 1);
      end
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check(bqd_pkg::result_t got);
      bqd_pkg::result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected result value=%h", got.value);
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value) begin
        errors++;
        $error("value expected %h actual %h", exp.value, got.value);
      end
      if (got.position !== exp.position) begin
        errors++;
        $error("position expected %0d actual %0d", exp.position, got.position);
      end
      if (got.block_done !== exp.block_done) begin
        errors++;
        $error("block_done expected %b actual %b", exp.block_done, got.block_done);
      end
      if (got.last !== exp.last) begin
        errors++;
        $error("last expected %b actual %b", exp.last, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_data = 0;
  logic push = 0, pop = 0, restart = 0;
  logic [15:0] word = 0;
  logic full, empty, block_done, last;
  logic [31:0] value;
  logic [4:0] position;

  dequant_scoreboard sb = new();
  bit quiet = 0;
  bit long_hold = 0;
  int cycles = 0;

  block_quant_dequantizer DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .word(word), .restart(restart),
    .empty(empty), .pop(pop), .value(value), .position(position),
    .block_done(block_done), .last(last)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: checks accepted results and stalls at random.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check('{value, position, block_done, last});
      if (long_hold) begin
        long_hold = 0;
        hold = 300;
      end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 12);
      end
      if (hold > 0) begin
        hold--;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  // Offers one word and waits until the block takes the request.
  task automatic send_word(logic [15:0] w, logic rs);
    int gap;
    gap = (!quiet && $urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    word <= w;
    restart <= rs;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note(w, rs);
  endtask

  // Drains all predictions, lets trailing scale words settle, then writes format.
  task automatic set_format(logic [1:0] f);
    push <= 0;
    while (sb.pending.size() != 0 && cycles < 200000) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= f;
    @(posedge clk);
    cfg_we <= 0;
    sb.fmt = f;
  endtask

  // A scale word, now and then infinity, NaN or subnormal.
  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 16'h7c00 | 16'($urandom_range(0, 1)) << 15 | 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 1023)) | 16'($urandom_range(0, 1)) << 15;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random words in the current format, mostly whole blocks.
  task automatic random_phase(int n);
    int blen, k;
    blen = (sb.fmt == bqd_pkg::FMT_Q4) ? 9 : 17;
    k = 0;
    while (k < n) begin
      if (sb.fmt == bqd_pkg::FMT_F16 || sb.fmt == bqd_pkg::FMT_BF16 ||
          $urandom_range(0, 7) == 0) begin
        send_word(16'($urandom), 1'($urandom_range(0, 1)));
        k++;
      end else begin
        send_word(pick_scale(), 1'($urandom_range(0, 3) == 0));
        for (int i = 1; i < blen && k < n; i++) begin
          send_word(16'($urandom), 1'($urandom_range(0, 40) == 0));
          k++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: half extremes, zeros, subnormals, infinity and NaN.
    send_word(16'h0000, 1);
    send_word(16'h8000, 0);
    send_word(16'h7c00, 0);
    send_word(16'hfe01, 0);
    send_word(16'h0001, 0);
    send_word(16'h83ff, 0);
    send_word(16'h7bff, 0);
    set_format(bqd_pkg::FMT_BF16);
    send_word(16'hffff, 0);
    send_word(16'h8001, 1);
    // Negative scale with zero quants, then a NaN scale.
    set_format(bqd_pkg::FMT_Q4);
    send_word(16'hbc00, 1);
    send_word(16'h8888, 0);
    send_word(16'hf00f, 0);
    send_word(16'h7e00, 1);
    send_word(16'h0ff0, 0);
    // Subnormal scale with extreme int8 values; the block runs to its end.
    set_format(bqd_pkg::FMT_Q8);
    send_word(16'h0001, 1);
    send_word(16'h807f, 0);
    for (int i = 0; i < 15; i++) send_word(16'hff00 ^ 16'(i), 0);
    send_word(16'h3c00, 0);
    send_word(16'h7f80, 0);
    // Switch to q4_0 mid-block: the stale position starts a new block.
    set_format(bqd_pkg::FMT_Q8);
    for (int i = 0; i < 12; i++) send_word(16'($urandom), 0);
    set_format(bqd_pkg::FMT_Q4);
    send_word(16'h4000, 0);
    send_word(16'h1234, 0);

    // Random phases; one starts with the receiver held off to fill the block.
    set_format(bqd_pkg::FMT_Q4);
    long_hold = 1;
    random_phase(50);
    set_format(bqd_pkg::FMT_Q8);
    random_phase(45);
    set_format(bqd_pkg::FMT_F16);
    random_phase(30);
    set_format(bqd_pkg::FMT_BF16);
    random_phase(20);
    set_format(bqd_pkg::FMT_Q8);
    random_phase(25);
    set_format(bqd_pkg::FMT_Q4);
    quiet = 1;
    random_phase(50);
    push <= 0;

    while (sb.pending.size() != 0 && cycles < 200000) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
